/* design/sirc_tx_pkg.sv */
package sirc_tx_pkg;

  localparam int unsigned COMMAND_BITS = 7;
  localparam int unsigned ADDRESS_BITS = 5;
  localparam int unsigned TOTAL_BITS   = COMMAND_BITS + ADDRESS_BITS;
  localparam int unsigned BIT_IDX_W    = $clog2(TOTAL_BITS + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [5:0]  RST_CARRIER_HIGH = 6'd8;
  localparam logic [5:0]  RST_CARRIER_LOW  = 6'd18;
  localparam logic [7:0]  RST_START_BURST  = 8'd92;
  localparam logic [7:0]  RST_ONE_BURST    = 8'd46;
  localparam logic [7:0]  RST_ZERO_BURST   = 8'd23;
  localparam logic [11:0] RST_SPACE        = 12'd600;
  localparam logic [15:0] RST_TRAILER      = 16'd25000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARRIER_HIGH = 3'd0,
    CFG_CARRIER_LOW  = 3'd1,
    CFG_START_BURST  = 3'd2,
    CFG_ONE_BURST    = 3'd3,
    CFG_ZERO_BURST   = 3'd4,
    CFG_SPACE        = 3'd5,
    CFG_TRAILER      = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_BURST = 3'd1,
    PH_START_SPACE = 3'd2,
    PH_BIT_BURST   = 3'd3,
    PH_BIT_SPACE   = 3'd4,
    PH_TRAILER     = 3'd5
  } phase_e;

  typedef struct packed {
    logic                    opcode;
    logic [COMMAND_BITS-1:0] command;
    logic [ADDRESS_BITS-1:0] address;
  } in_beat_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
  } out_beat_t;

endpackage

/* design/sirc_ir_frame_transmitter_unit.sv */
// Channel  | Signals                              | Dir | Beat
// ---------+--------------------------------------+-----+------------------------------
// in       | in_valid_i / in_ready_o / in_data_i  | in  | opcode, command, address
// out      | out_valid_o / out_ready_i/out_data_o | out | ir_level, busy_res, frame_done
// cfg      | cfg_we_i / cfg_idx_i / cfg_wdata_i   | in  | register write, no wait
//
// One beat per clock while the output is not stalled: each tick updates the
// frame state and loads the result register in the same cycle.
// The result register sets the rate: in_ready_o is high while it is empty or
// being drained, so a stalled output holds one beat and blocks further input.
// Reset (rst_ni low, async) idles the frame and restores register defaults.
module sirc_ir_frame_transmitter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  sirc_tx_pkg::in_beat_t                in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output sirc_tx_pkg::out_beat_t               out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [sirc_tx_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sirc_tx_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned TB = sirc_tx_pkg::TOTAL_BITS;
  localparam int unsigned BW = sirc_tx_pkg::BIT_IDX_W;

  logic [5:0]  carrier_high_q, carrier_low_q;
  logic [7:0]  start_burst_q, one_burst_q, zero_burst_q;
  logic [11:0] space_q;
  logic [15:0] trailer_q;

  sirc_tx_pkg::phase_e phase_q, phase_d;
  logic [TB-1:0] frame_bits_q, frame_bits_d;
  logic [BW-1:0] bit_index_q, bit_index_d;
  logic [7:0]    burst_left_q, burst_left_d;
  logic [6:0]    period_tick_q, period_tick_d;
  logic [15:0]   silence_q, silence_d;

  logic                   out_valid_q;
  sirc_tx_pkg::out_beat_t out_q, out_d;

  logic in_fire;

  logic [6:0]  period, pt_inc;
  logic [7:0]  bl_dec, one_len, zero_len;
  logic [15:0] sl_dec, space_len;
  logic [BW-1:0] bi_inc;
  logic          start;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_high_q <= sirc_tx_pkg::RST_CARRIER_HIGH;
      carrier_low_q  <= sirc_tx_pkg::RST_CARRIER_LOW;
      start_burst_q  <= sirc_tx_pkg::RST_START_BURST;
      one_burst_q    <= sirc_tx_pkg::RST_ONE_BURST;
      zero_burst_q   <= sirc_tx_pkg::RST_ZERO_BURST;
      space_q        <= sirc_tx_pkg::RST_SPACE;
      trailer_q      <= sirc_tx_pkg::RST_TRAILER;
    end else if (cfg_we_i) begin
      case (sirc_tx_pkg::cfg_reg_e'(cfg_idx_i))
        sirc_tx_pkg::CFG_CARRIER_HIGH: carrier_high_q <= cfg_wdata_i[5:0];
        sirc_tx_pkg::CFG_CARRIER_LOW:  carrier_low_q  <= cfg_wdata_i[5:0];
        sirc_tx_pkg::CFG_START_BURST:  start_burst_q  <= cfg_wdata_i[7:0];
        sirc_tx_pkg::CFG_ONE_BURST:    one_burst_q    <= cfg_wdata_i[7:0];
        sirc_tx_pkg::CFG_ZERO_BURST:   zero_burst_q   <= cfg_wdata_i[7:0];
        sirc_tx_pkg::CFG_SPACE:        space_q        <= cfg_wdata_i[11:0];
        sirc_tx_pkg::CFG_TRAILER:      trailer_q      <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // zero lengths count as one
  assign one_len   = (one_burst_q == 8'd0) ? 8'd1 : one_burst_q;
  assign zero_len  = (zero_burst_q == 8'd0) ? 8'd1 : zero_burst_q;
  assign space_len = (space_q == 12'd0) ? 16'd1 : {4'd0, space_q};
  assign start     = in_data_i.opcode && (phase_q == sirc_tx_pkg::PH_IDLE);

  always_comb begin
    sirc_tx_pkg::phase_e ph;
    logic [TB-1:0] fb;
    logic [BW-1:0] bi;
    logic [7:0]    bl;
    logic [6:0]    pt;
    logic [15:0]   sl;

    ph = phase_q;
    fb = frame_bits_q;
    bi = bit_index_q;
    bl = burst_left_q;
    pt = period_tick_q;
    sl = silence_q;
    if (start) begin
      ph = sirc_tx_pkg::PH_START_BURST;
      fb = {in_data_i.address, in_data_i.command};
      bi = '0;
      bl = (start_burst_q == 8'd0) ? 8'd1 : start_burst_q;
      pt = '0;
      sl = '0;
    end

    period = {1'b0, carrier_high_q} + {1'b0, carrier_low_q};
    if (period == 7'd0) period = 7'd1;
    pt_inc = pt + 7'd1;
    bl_dec = (bl != 8'd0) ? bl - 8'd1 : 8'd0;
    sl_dec = (sl != 16'd0) ? sl - 16'd1 : 16'd0;
    bi_inc = bi + BW'(1);

    phase_d       = ph;
    frame_bits_d  = fb;
    bit_index_d   = bi;
    burst_left_d  = bl;
    period_tick_d = pt;
    silence_d     = sl;
    out_d         = '0;
    out_d.busy_res = (ph != sirc_tx_pkg::PH_IDLE);

    case (ph)
      sirc_tx_pkg::PH_START_BURST, sirc_tx_pkg::PH_BIT_BURST: begin
        out_d.ir_level = (pt < {1'b0, carrier_high_q});
        period_tick_d  = pt_inc;
        if (pt_inc >= period) begin
          period_tick_d = '0;
          burst_left_d  = bl_dec;
          if (bl_dec == 8'd0) begin
            phase_d   = (ph == sirc_tx_pkg::PH_START_BURST) ?
                        sirc_tx_pkg::PH_START_SPACE : sirc_tx_pkg::PH_BIT_SPACE;
            silence_d = space_len;
          end
        end
      end
      sirc_tx_pkg::PH_START_SPACE: begin
        silence_d = sl_dec;
        if (sl_dec == 16'd0) begin
          bit_index_d   = '0;
          phase_d       = sirc_tx_pkg::PH_BIT_BURST;
          period_tick_d = '0;
          burst_left_d  = fb[0] ? one_len : zero_len;
        end
      end
      sirc_tx_pkg::PH_BIT_SPACE: begin
        silence_d = sl_dec;
        if (sl_dec == 16'd0) begin
          bit_index_d = bi_inc;
          if (bi_inc < BW'(TB)) begin
            phase_d       = sirc_tx_pkg::PH_BIT_BURST;
            period_tick_d = '0;
            burst_left_d  = fb[bi_inc] ? one_len : zero_len;
          end else if (trailer_q == 16'd0) begin
            phase_d          = sirc_tx_pkg::PH_IDLE;
            out_d.frame_done = 1'b1;
          end else begin
            phase_d   = sirc_tx_pkg::PH_TRAILER;
            silence_d = trailer_q;
          end
        end
      end
      sirc_tx_pkg::PH_TRAILER: begin
        silence_d = sl_dec;
        if (sl_dec == 16'd0) begin
          phase_d          = sirc_tx_pkg::PH_IDLE;
          out_d.frame_done = 1'b1;
        end
      end
      default: phase_d = sirc_tx_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= sirc_tx_pkg::PH_IDLE;
      frame_bits_q  <= '0;
      bit_index_q   <= '0;
      burst_left_q  <= '0;
      period_tick_q <= '0;
      silence_q     <= '0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      frame_bits_q  <= frame_bits_d;
      bit_index_q   <= bit_index_d;
      burst_left_q  <= burst_left_d;
      period_tick_q <= period_tick_d;
      silence_q     <= silence_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_done |-> out_q.busy_res)
    else $error("frame_done without busy");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_data_i.opcode && (phase_q == sirc_tx_pkg::PH_IDLE)
    |=> !out_q.busy_res && !out_q.ir_level)
    else $error("idle tick reported activity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && out_d.frame_done |=> phase_q == sirc_tx_pkg::PH_IDLE)
    else $error("frame_done without return to idle");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_index_q <= BW'(TB))
    else $error("bit index out of range");

endmodule
